// ===== hw/rtl/cacb_pkg.sv =====
// shared types, constants and register codes for the clipped alpha color blend core
// no dependencies
`default_nettype none

package cacb_pkg;

  localparam int MAX_CANVAS = 4096;
  localparam int MAX_MASK   = 1024;

  localparam int TargetW = $clog2(MAX_CANVAS);
  localparam int MaskW   = $clog2(MAX_MASK);
  localparam int OffsetW = 13;
  localparam int SizeW   = 13;
  localparam int MaskCfgW = 11;
  localparam int ChanW   = 8;
  localparam int SumW    = 2 * ChanW;
  localparam int CoordW  = OffsetW + 1;
  localparam int CfgDataW = 13;
  localparam int CfgIdxW = 3;
  localparam int Lanes   = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OFFSET_X      = 3'd0,
    REG_OFFSET_Y      = 3'd1,
    REG_MASK_WIDTH    = 3'd2,
    REG_CANVAS_WIDTH  = 3'd3,
    REG_CANVAS_HEIGHT = 3'd4,
    REG_COLOR_BLUE    = 3'd5,
    REG_COLOR_GREEN   = 3'd6,
    REG_COLOR_RED     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [ChanW-1:0] mask_alpha;
    logic [ChanW-1:0] bg_blue;
    logic [ChanW-1:0] bg_green;
    logic [ChanW-1:0] bg_red;
    logic             mask_end;
  } pixel_t;

  typedef struct packed {
    logic               write_enable;
    logic [TargetW-1:0] target_x;
    logic [TargetW-1:0] target_y;
    logic [ChanW-1:0]   out_blue;
    logic [ChanW-1:0]   out_green;
    logic [ChanW-1:0]   out_red;
  } result_t;

  typedef struct packed {
    logic               in_canvas;
    logic [TargetW-1:0] x;
    logic [TargetW-1:0] y;
  } target_t;

  typedef struct packed {
    logic signed [OffsetW-1:0] offset_x;
    logic signed [OffsetW-1:0] offset_y;
    logic [MaskCfgW-1:0]       mask_width;
    logic [SizeW-1:0]          canvas_width;
    logic [SizeW-1:0]          canvas_height;
  } geom_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cacb_addr.sv =====
// mask column and row counters and canvas target check
// depends on cacb_pkg
`default_nettype none

module cacb_addr (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cacb_pkg::geom_t geom,
  input  wire logic            advance,
  input  wire logic            mask_end,
  output cacb_pkg::target_t    target
);

  logic [cacb_pkg::MaskW-1:0]    column;
  logic [cacb_pkg::MaskW-1:0]    row;
  logic [cacb_pkg::MaskW-1:0]    column_next;
  logic [cacb_pkg::MaskW-1:0]    row_next;
  logic [cacb_pkg::MaskCfgW-1:0] eff_width;
  logic [cacb_pkg::MaskCfgW-1:0] column_inc;
  logic [cacb_pkg::SizeW-1:0]    eff_cw;
  logic [cacb_pkg::SizeW-1:0]    eff_ch;
  logic signed [cacb_pkg::CoordW-1:0] tx;
  logic signed [cacb_pkg::CoordW-1:0] ty;
  logic inside_x;
  logic inside_y;

  always_comb begin
    if (geom.mask_width == '0) begin
      eff_width = cacb_pkg::MaskCfgW'(1);
    end else if (geom.mask_width > cacb_pkg::MaskCfgW'(cacb_pkg::MAX_MASK)) begin
      eff_width = cacb_pkg::MaskCfgW'(cacb_pkg::MAX_MASK);
    end else begin
      eff_width = geom.mask_width;
    end
    eff_cw = (geom.canvas_width > cacb_pkg::SizeW'(cacb_pkg::MAX_CANVAS)) ?
             cacb_pkg::SizeW'(cacb_pkg::MAX_CANVAS) : geom.canvas_width;
    eff_ch = (geom.canvas_height > cacb_pkg::SizeW'(cacb_pkg::MAX_CANVAS)) ?
             cacb_pkg::SizeW'(cacb_pkg::MAX_CANVAS) : geom.canvas_height;

    tx = cacb_pkg::CoordW'(geom.offset_x) + $signed(cacb_pkg::CoordW'(column));
    ty = cacb_pkg::CoordW'(geom.offset_y) + $signed(cacb_pkg::CoordW'(row));
    inside_x = !tx[cacb_pkg::CoordW-1] && (tx[cacb_pkg::CoordW-2:0] < eff_cw);
    inside_y = !ty[cacb_pkg::CoordW-1] && (ty[cacb_pkg::CoordW-2:0] < eff_ch);

    target.in_canvas = inside_x && inside_y;
    target.x         = tx[cacb_pkg::TargetW-1:0];
    target.y         = ty[cacb_pkg::TargetW-1:0];

    column_inc = cacb_pkg::MaskCfgW'(column) + cacb_pkg::MaskCfgW'(1);
    if (mask_end) begin
      column_next = '0;
      row_next    = '0;
    end else if (column_inc >= eff_width) begin
      column_next = '0;
      row_next    = row + cacb_pkg::MaskW'(1);
    end else begin
      column_next = column_inc[cacb_pkg::MaskW-1:0];
      row_next    = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (advance) begin
      column <= column_next;
      row    <= row_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cacb_lane.sv =====
// one color channel: weighted sum register and exact divide by 255
// depends on cacb_pkg
`default_nettype none

module cacb_lane (
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire logic [cacb_pkg::ChanW-1:0] color,
  input  wire logic [cacb_pkg::ChanW-1:0] bg,
  input  wire logic [cacb_pkg::ChanW-1:0] alpha,
  output logic      [cacb_pkg::ChanW-1:0] blend
);

  logic [cacb_pkg::SumW-1:0]   sum;
  logic [cacb_pkg::SumW-1:0]   sum_next;
  logic [cacb_pkg::ChanW-1:0]  inv_alpha;
  logic [cacb_pkg::SumW:0]     quot;

  always_comb begin
    inv_alpha = ~alpha;
    sum_next  = cacb_pkg::SumW'(color * alpha) + cacb_pkg::SumW'(bg * inv_alpha);
    // floor(x / 255) for x up to 255 * 255
    quot  = (cacb_pkg::SumW+1)'(sum) + (cacb_pkg::SumW+1)'(sum >> cacb_pkg::ChanW)
            + (cacb_pkg::SumW+1)'(1);
    blend = quot[cacb_pkg::SumW-1:cacb_pkg::ChanW];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/clipped_alpha_color_blend_core.sv =====
// Blends a solid color over a streamed background through a coverage mask, one pixel per
// transfer in mask raster order. A new pixel is taken every clock unless stalled; each
// result passes through an input/target register, one multiply-add register per color
// lane, and the output register that merges the lanes. Stall on the result side holds the
// pipeline and back-pressures the pixel side. Registers load from cfg_write directly.
// depends on cacb_pkg, cacb_addr, cacb_lane
`default_nettype none

module clipped_alpha_color_blend_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [cacb_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [cacb_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic                          pixel_valid,
  output logic                               pixel_stall,
  input  wire cacb_pkg::pixel_t              pixel,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output cacb_pkg::result_t                  result
);

  localparam int ChanW   = cacb_pkg::ChanW;
  localparam int TargetW = cacb_pkg::TargetW;
  localparam int Lanes   = cacb_pkg::Lanes;

  cacb_pkg::geom_t geom;
  logic [Lanes-1:0][ChanW-1:0] color;

  cacb_pkg::target_t target;
  logic accept;
  logic out_ready;
  logic s2_ready;
  logic s1_ready;

  logic                        s1_valid;
  logic                        s1_we;
  logic [TargetW-1:0]          s1_x;
  logic [TargetW-1:0]          s1_y;
  logic [ChanW-1:0]            s1_alpha;
  logic [Lanes-1:0][ChanW-1:0] s1_bg;

  logic                        s2_valid;
  logic                        s2_we;
  logic [TargetW-1:0]          s2_x;
  logic [TargetW-1:0]          s2_y;
  logic [Lanes-1:0][ChanW-1:0] s2_bg;
  logic [Lanes-1:0][ChanW-1:0] blend;

  cacb_pkg::result_t result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.offset_x      <= '0;
      geom.offset_y      <= '0;
      geom.mask_width    <= cacb_pkg::MaskCfgW'(1);
      geom.canvas_width  <= cacb_pkg::SizeW'(cacb_pkg::MAX_CANVAS);
      geom.canvas_height <= cacb_pkg::SizeW'(cacb_pkg::MAX_CANVAS);
      color              <= '0;
    end else if (cfg_write) begin
      case (cacb_pkg::cfg_reg_t'(cfg_index))
        cacb_pkg::REG_OFFSET_X:      geom.offset_x <= cfg_data[cacb_pkg::OffsetW-1:0];
        cacb_pkg::REG_OFFSET_Y:      geom.offset_y <= cfg_data[cacb_pkg::OffsetW-1:0];
        cacb_pkg::REG_MASK_WIDTH:    geom.mask_width <= cfg_data[cacb_pkg::MaskCfgW-1:0];
        cacb_pkg::REG_CANVAS_WIDTH:  geom.canvas_width <= cfg_data[cacb_pkg::SizeW-1:0];
        cacb_pkg::REG_CANVAS_HEIGHT: geom.canvas_height <= cfg_data[cacb_pkg::SizeW-1:0];
        cacb_pkg::REG_COLOR_BLUE:    color[0] <= cfg_data[ChanW-1:0];
        cacb_pkg::REG_COLOR_GREEN:   color[1] <= cfg_data[ChanW-1:0];
        cacb_pkg::REG_COLOR_RED:     color[2] <= cfg_data[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  always_comb begin
    out_ready   = !result_valid || !result_stall;
    s2_ready    = !s2_valid || out_ready;
    s1_ready    = !s1_valid || s2_ready;
    pixel_stall = !s1_ready;
    accept      = pixel_valid && s1_ready;
  end

  cacb_addr u_addr (
    .clk      (clk),
    .rst      (rst),
    .geom     (geom),
    .advance  (accept),
    .mask_end (pixel.mask_end),
    .target   (target)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pixel_valid;
    end
    if (s1_ready) begin
      s1_we    <= target.in_canvas && (pixel.mask_alpha != '0);
      s1_x     <= target.x;
      s1_y     <= target.y;
      s1_alpha <= pixel.mask_alpha;
      s1_bg    <= {pixel.bg_red, pixel.bg_green, pixel.bg_blue};
    end
  end

  for (genvar i = 0; i < Lanes; i++) begin : g_lane
    cacb_lane u_lane (
      .clk   (clk),
      .load  (s2_ready),
      .color (color[i]),
      .bg    (s1_bg[i]),
      .alpha (s1_alpha),
      .blend (blend[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready) begin
      s2_we <= s1_we;
      s2_x  <= s1_x;
      s2_y  <= s1_y;
      s2_bg <= s1_bg;
    end
  end

  // merge lanes into the result
  always_comb begin
    result_next.write_enable = s2_we;
    if (s2_we) begin
      result_next.target_x  = s2_x;
      result_next.target_y  = s2_y;
      result_next.out_blue  = blend[0];
      result_next.out_green = blend[1];
      result_next.out_red   = blend[2];
    end else begin
      result_next.target_x  = '0;
      result_next.target_y  = '0;
      result_next.out_blue  = s2_bg[0];
      result_next.out_green = s2_bg[1];
      result_next.out_red   = s2_bg[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= s2_valid;
    end
    if (out_ready) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_target_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.write_enable |-> result.target_x == '0 && result.target_y == '0)
    else $error("unwritten result carries a nonzero target");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> s1_valid && s2_valid && result_valid && result_stall)
    else $error("pixel side stalled with room in the pipeline");

  a_write_in_canvas: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.write_enable |->
      {1'b0, result.target_x} < geom.canvas_width &&
      {1'b0, result.target_y} < geom.canvas_height)
    else $error("write target outside canvas");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !result_valid && !s1_valid && !s2_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
